// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test package
// Shared opcodes and the control/status bundles of the edge test unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

    // Request opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Control from the sequencer to the edge test unit.
    typedef struct packed {
        logic clear;   // start of a query: parity goes back to even
        logic valid;   // an edge is presented this cycle
        logic last;    // this edge closes the polygon
    } pip_edge_ctl_t;

    // Status from the edge test unit back to the sequencer.
    typedef struct packed {
        logic done;    // last edge has been folded into the parity
        logic odd;     // running crossing parity
    } pip_edge_sts_t;

endpackage

`default_nettype wire

// ===== rtl/pip_vertex_mem.sv =====
// ----------------------------------------------------------------------------
// Vertex memory
// One write port and one registered read port holding packed (x, y) pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_vertex_mem #(
    parameter int DEPTH = 64,
    parameter int CW    = 16,
    parameter int AW    = 6
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic signed [CW-1:0] wx,
    input  wire logic signed [CW-1:0] wy,
    input  wire logic                 re,
    input  wire logic [AW-1:0]        raddr,
    output logic signed [CW-1:0]      rx,
    output logic signed [CW-1:0]      ry
);

    logic [2*CW-1:0] mem [DEPTH];
    logic [2*CW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wx, wy};
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rx = signed'(rdata_reg[2*CW-1:CW]);
    assign ry = signed'(rdata_reg[CW-1:0]);

endmodule

`default_nettype wire

// ===== rtl/pip_edge_unit.sv =====
// ----------------------------------------------------------------------------
// Edge crossing test unit
// Pipelined crossing-number test of one edge per cycle with a parity flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge_unit #(
    parameter int CW = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pip_pkg::pip_edge_ctl_t ctl,
    input  wire logic signed [CW-1:0]   px,
    input  wire logic signed [CW-1:0]   py,
    input  wire logic signed [CW-1:0]   xi,
    input  wire logic signed [CW-1:0]   yi,
    input  wire logic signed [CW-1:0]   xj,
    input  wire logic signed [CW-1:0]   yj,
    output pip_pkg::pip_edge_sts_t      sts
);

    import pip_pkg::*;

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic                 yi_lt;
    logic                 yj_lt;
    logic                 hit;
    logic signed [DW-1:0] a1;
    logic signed [DW-1:0] b1;
    logic signed [DW-1:0] a2;
    logic signed [DW-1:0] dy;

    // Stage 1 registers.
    logic                 v1_reg;
    logic                 last1_reg;
    logic                 hit1_reg;
    logic                 pos1_reg;
    logic signed [DW-1:0] a1_reg;
    logic signed [DW-1:0] b1_reg;
    logic signed [DW-1:0] a2_reg;
    logic signed [DW-1:0] dy1_reg;

    // Stage 2 registers.
    logic                 v2_reg;
    logic                 last2_reg;
    logic                 hit2_reg;
    logic                 pos2_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;

    logic                 toggle;
    logic                 odd_reg;
    logic                 done_reg;

    assign yi_lt = yi < py;
    assign yj_lt = yj < py;
    assign hit   = ((yi_lt && !yj_lt) || (yj_lt && !yi_lt)) && ((xi <= px) || (xj <= px));
    assign a1    = DW'(py) - DW'(yi);
    assign b1    = DW'(xj) - DW'(xi);
    assign a2    = DW'(px) - DW'(xi);
    assign dy    = DW'(yj) - DW'(yi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
            v2_reg    <= 1'b0;
            last2_reg <= 1'b0;
            odd_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v1_reg    <= ctl.valid;
            last1_reg <= ctl.valid && ctl.last;
            v2_reg    <= v1_reg;
            last2_reg <= v1_reg && last1_reg;
            done_reg  <= v2_reg && last2_reg;
            if (ctl.clear)
            begin
                odd_reg <= 1'b0;
            end
            else if (v2_reg && toggle)
            begin
                odd_reg <= !odd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit1_reg <= hit;
        pos1_reg <= dy > 0;
        a1_reg   <= a1;
        b1_reg   <= b1;
        a2_reg   <= a2;
        dy1_reg  <= dy;
        hit2_reg <= hit1_reg;
        pos2_reg <= pos1_reg;
        p1_reg   <= PW'(a1_reg) * PW'(b1_reg);
        p2_reg   <= PW'(a2_reg) * PW'(dy1_reg);
    end

    // A straddling edge never has a zero y span, so the sign picks the test.
    assign toggle = hit2_reg && (pos2_reg ? (p1_reg < p2_reg) : (p1_reg > p2_reg));

    assign sts.done = done_reg;
    assign sts.odd  = odd_reg;

endmodule

`default_nettype wire

// ===== rtl/point_in_polygon_test_unit.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test unit
// Crossing-number inside test against a stored polygon, one edge per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready. A write request (opcode write)
//   stores coord_x/coord_y in vertex_slot; slots at or
//   above MAX_VERTICES are dropped. A query request (opcode query) tests the
//   point against vertices 0 .. n-1, where n is vertex_count saturated to
//   MAX_VERTICES, and returns one inside_res on out_valid/out_ready.
//   Writes give no result.
//   A query holds in_ready low until its result is registered: the
//   vertex memory's single read port delivers one vertex per cycle
//   (n + 1 reads, the last vertex first to close the polygon) into a
//   three-stage edge pipeline. n = 0 answers outside without reading
//   any vertex. vertex_count is to be written on cfg_wr_en only while
//   the block is idle; the block itself does not enforce this.
//   Reset clears vertex_count and the control state; vertex contents stay
//   undefined until written. If the receiver stalls, the finished result
//   waits in the output register; writes are still taken, and a following
//   query waits for the output register to free up before it completes.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [6:0]                   cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         opcode,
    input  wire logic [5:0]                   vertex_slot,
    input  wire logic signed [COORD_BITS-1:0] coord_x,
    input  wire logic signed [COORD_BITS-1:0] coord_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              inside_res
);

    import pip_pkg::*;

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int NW   = (CNTW > 7) ? CNTW : 7;
    // One bit above the slot field so that MAX_VERTICES itself fits.
    localparam int SW   = ((AW > 6) ? AW : 6) + 1;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_VERTICES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [6:0]              count_reg;
    logic [NW-1:0]           count_ext;
    logic [NW-1:0]           n_eff;
    logic [NW-1:0]           n_reg;
    logic [NW-1:0]           issue_cnt_reg;
    logic                    issuing_reg;
    logic                    rd_valid_reg;
    logic                    rd_first_reg;
    logic                    rd_last_reg;
    logic                    out_valid_reg;
    logic                    inside_res_reg;
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;

    logic                    in_acc;
    logic                    query_acc;
    logic [SW-1:0]           slot_ext;
    logic                    mem_we;
    logic [NW-1:0]           rd_addr_full;
    pip_edge_ctl_t           edge_ctl;
    pip_edge_sts_t           edge_sts;

    assign in_ready  = state_reg == ST_IDLE;
    assign in_acc    = in_valid && in_ready;
    assign query_acc = in_acc && (opcode == OP_QUERY);

    assign count_ext = NW'(count_reg);
    assign n_eff     = (count_ext > MAX_N) ? MAX_N : count_ext;

    assign slot_ext  = SW'(vertex_slot);
    assign mem_we    = in_acc && (opcode == OP_WRITE) && (slot_ext < SW'(MAX_VERTICES));

    // The first read fetches the last vertex so that it closes the polygon.
    assign rd_addr_full = (issue_cnt_reg == '0) ? (n_reg - 1'b1) : (issue_cnt_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            n_reg          <= '0;
            issue_cnt_reg  <= '0;
            issuing_reg    <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            inside_res_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issuing_reg;
            rd_first_reg <= issue_cnt_reg == '0;
            rd_last_reg  <= issue_cnt_reg == n_reg;
            if (out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (query_acc)
                    begin
                        n_reg         <= n_eff;
                        issue_cnt_reg <= '0;
                        issuing_reg   <= n_eff != '0;
                        state_reg     <= (n_eff == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (issuing_reg)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                        if (issue_cnt_reg == n_reg)
                        begin
                            issuing_reg <= 1'b0;
                        end
                    end
                    if (edge_sts.done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        inside_res_reg <= edge_sts.odd;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rd_valid_reg)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
        end
    end

    pip_vertex_mem #(
        .DEPTH (MAX_VERTICES),
        .CW    (COORD_BITS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_ext[AW-1:0]),
        .wx    (coord_x),
        .wy    (coord_y),
        .re    (issuing_reg),
        .raddr (rd_addr_full[AW-1:0]),
        .rx    (rd_x),
        .ry    (rd_y)
    );

    assign edge_ctl.clear = query_acc;
    assign edge_ctl.valid = rd_valid_reg && !rd_first_reg;
    assign edge_ctl.last  = rd_last_reg;

    pip_edge_unit #(
        .CW (COORD_BITS)
    ) u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (edge_ctl),
        .px    (px_reg),
        .py    (py_reg),
        .xi    (rd_x),
        .yi    (rd_y),
        .xj    (prev_x_reg),
        .yj    (prev_y_reg),
        .sts   (edge_sts)
    );

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_res_reg;

    // A result only appears as the sequencer leaves its finishing state.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the finishing state");

    // While new requests are taken, no vertex read may still be in flight.
    a_idle_no_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!rd_valid_reg && !issuing_reg))
        else $error("vertex read pending while accepting requests");

    // The edge pipeline reports completion only during a query walk.
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        edge_sts.done |-> (state_reg == ST_RUN))
        else $error("edge walk completed outside a query");

    // Reads stop right after the closing vertex has been issued.
    a_issue_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (issuing_reg && (issue_cnt_reg == n_reg)) |=> !issuing_reg)
        else $error("vertex reads continued past the polygon");

endmodule

`default_nettype wire
